// File: rtl/blpl_pkg.sv
// Shared types, codes and helper functions for the button/LED pad link controller.
// No dependencies; every other file in rtl/ refers to it by scoped names.
package blpl_pkg;

  // Packet opcodes received from the pad
  localparam logic [7:0] OP_RESET        = 8'd66;
  localparam logic [7:0] OP_ACK          = 8'd64;
  localparam logic [7:0] OP_BUTTON_EVENT = 8'd65;

  // Command bytes sent to the pad
  localparam logic [7:0] CMD_LED_SET       = 8'd6;
  localparam logic [7:0] CMD_BUTTON_IRQ_ON = 8'd3;
  localparam logic [7:0] CMD_LED_USER      = 8'd5;

  localparam logic [7:0]  LED_ALL_DIGITS = 8'h0F;
  localparam logic [7:0]  SEG_DP         = 8'h10;
  localparam logic [7:0]  BUTTONS_IDLE   = 8'hFF;
  localparam logic [31:0] LED_WORD_CLEAR = 32'h0;

  // Command queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_PTR_W = 1;
  localparam int unsigned QUEUE_CNT_W = 2;

  // Widest byte sequence is the resend: IRQ on plus six-byte frame
  localparam int unsigned SEQ_IDX_W = 3;

  typedef enum logic [1:0] {
    OP_PACKET       = 2'd0,
    OP_INIT         = 2'd1,
    OP_READ_BUTTONS = 2'd2,
    OP_SET_LEDS     = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_BUSY    = 2'd1,
    STATUS_UNKNOWN = 2'd2
  } status_e;

  // What the back end has to send for one event
  typedef enum logic [1:0] {
    KIND_NONE   = 2'd0,
    KIND_INIT   = 2'd1,
    KIND_FRAME  = 2'd2,
    KIND_RESEND = 2'd3
  } cmd_kind_e;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  pkt_opcode;
    logic [7:0]  pkt_byte_b;
    logic [7:0]  pkt_byte_c;
    logic [31:0] led_word;
  } in_item_t;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic [7:0] buttons;
    logic [1:0] status;
    logic       last;
  } out_item_t;

  typedef struct packed {
    cmd_kind_e   kind;
    logic [31:0] word;
    logic [7:0]  buttons;
    status_e     status;
  } cmd_t;

  function automatic logic [7:0] seg_font(input logic [3:0] hex);
    logic [7:0] seg;
    case (hex)
      4'h0:    seg = 8'hE7;
      4'h1:    seg = 8'h06;
      4'h2:    seg = 8'hCB;
      4'h3:    seg = 8'h8F;
      4'h4:    seg = 8'h2E;
      4'h5:    seg = 8'hAD;
      4'h6:    seg = 8'hED;
      4'h7:    seg = 8'h86;
      4'h8:    seg = 8'hEF;
      4'h9:    seg = 8'hAE;
      4'hA:    seg = 8'hEE;
      4'hB:    seg = 8'h6D;
      4'hC:    seg = 8'hE1;
      4'hD:    seg = 8'h4F;
      4'hE:    seg = 8'hE9;
      default: seg = 8'hE8;
    endcase
    return seg;
  endfunction

  // Byte pos of a six-byte LED frame
  function automatic logic [7:0] frame_byte(input logic [31:0] word,
                                            input logic [SEQ_IDX_W-1:0] pos);
    logic [SEQ_IDX_W-1:0] dpos;
    logic [1:0]           d;
    logic [7:0]           seg;
    dpos = pos - SEQ_IDX_W'(2);
    d    = dpos[1:0];
    seg  = 8'h00;
    case (pos)
      SEQ_IDX_W'(0): seg = CMD_LED_SET;
      SEQ_IDX_W'(1): seg = LED_ALL_DIGITS;
      default: begin
        if (word[{3'b100, d}]) begin
          seg = seg_font(word[{d, 2'b00} +: 4]);
          if (word[{3'b110, d}]) seg = seg | SEG_DP;
        end
      end
    endcase
    return seg;
  endfunction

  // Active-low raw bytes to active-high right,left,down,up,c,b,a,start
  function automatic logic [7:0] remap_buttons(input logic [7:0] low_raw,
                                               input logic [7:0] dir_raw);
    return {~dir_raw[3], ~dir_raw[1], ~dir_raw[2], ~dir_raw[0], ~low_raw[3:0]};
  endfunction

endpackage

// File: rtl/blpl_front.sv
// Front end: takes events, updates busy/button/LED state, queues a command.
// Depends on blpl_pkg.
module blpl_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  blpl_pkg::in_item_t in_item_i,
  input  logic               q_full_i,
  output logic               q_push_o,
  output blpl_pkg::cmd_t     q_cmd_o
);

  logic        busy_q, busy_d;
  logic [7:0]  btn_low_q, btn_low_d;
  logic [7:0]  btn_dir_q, btn_dir_d;
  logic [31:0] saved_word_q, saved_word_d;
  logic        accept;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign q_push_o   = accept;

  always_comb begin
    busy_d         = busy_q;
    btn_low_d      = btn_low_q;
    btn_dir_d      = btn_dir_q;
    saved_word_d   = saved_word_q;
    q_cmd_o.kind   = blpl_pkg::KIND_NONE;
    q_cmd_o.word   = saved_word_q;
    q_cmd_o.status = blpl_pkg::STATUS_OK;

    case (blpl_pkg::op_e'(in_item_i.op))
      blpl_pkg::OP_PACKET: begin
        if (in_item_i.pkt_opcode == blpl_pkg::OP_RESET) begin
          // pad came back from reset: resend IRQ enable and the last frame
          q_cmd_o.kind = blpl_pkg::KIND_RESEND;
          btn_low_d    = blpl_pkg::BUTTONS_IDLE;
          btn_dir_d    = blpl_pkg::BUTTONS_IDLE;
          busy_d       = 1'b1;
        end else if (in_item_i.pkt_opcode == blpl_pkg::OP_ACK) begin
          busy_d = 1'b0;
        end else if (in_item_i.pkt_opcode == blpl_pkg::OP_BUTTON_EVENT) begin
          btn_low_d = in_item_i.pkt_byte_b;
          btn_dir_d = in_item_i.pkt_byte_c;
        end else begin
          q_cmd_o.status = blpl_pkg::STATUS_UNKNOWN;
        end
      end
      blpl_pkg::OP_INIT: begin
        btn_low_d    = blpl_pkg::BUTTONS_IDLE;
        btn_dir_d    = blpl_pkg::BUTTONS_IDLE;
        saved_word_d = blpl_pkg::LED_WORD_CLEAR;
        if (busy_q) q_cmd_o.status = blpl_pkg::STATUS_BUSY;
        else        q_cmd_o.kind   = blpl_pkg::KIND_INIT;
      end
      blpl_pkg::OP_SET_LEDS: begin
        if (busy_q) begin
          q_cmd_o.status = blpl_pkg::STATUS_BUSY;
        end else begin
          q_cmd_o.kind = blpl_pkg::KIND_FRAME;
          q_cmd_o.word = in_item_i.led_word;
          saved_word_d = in_item_i.led_word;
          busy_d       = 1'b1;
        end
      end
      default: ;
    endcase

    q_cmd_o.buttons = blpl_pkg::remap_buttons(btn_low_d, btn_dir_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q       <= 1'b0;
      btn_low_q    <= blpl_pkg::BUTTONS_IDLE;
      btn_dir_q    <= blpl_pkg::BUTTONS_IDLE;
      saved_word_q <= blpl_pkg::LED_WORD_CLEAR;
    end else if (accept) begin
      busy_q       <= busy_d;
      btn_low_q    <= btn_low_d;
      btn_dir_q    <= btn_dir_d;
      saved_word_q <= saved_word_d;
    end
  end

endmodule

// File: rtl/blpl_queue.sv
// Two-entry command queue between front and back end.
// Depends on blpl_pkg.
module blpl_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  blpl_pkg::cmd_t push_cmd_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output blpl_pkg::cmd_t head_o
);

  blpl_pkg::cmd_t                       entry_q [blpl_pkg::QUEUE_DEPTH];
  logic [blpl_pkg::QUEUE_PTR_W-1:0]     wr_ptr_q, rd_ptr_q;
  logic [blpl_pkg::QUEUE_CNT_W-1:0]     count_q;

  assign full_o  = count_q == blpl_pkg::QUEUE_CNT_W'(blpl_pkg::QUEUE_DEPTH);
  assign empty_o = count_q == '0;
  assign head_o  = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) entry_q[wr_ptr_q] <= push_cmd_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop_i)  rd_ptr_q <= rd_ptr_q + 1'b1;
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

`ifndef SYNTH
  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i)
    else $error("queue pushed while full");

  a_no_underflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_o |-> !pop_i)
    else $error("queue popped while empty");
`endif

endmodule

// File: rtl/blpl_back.sv
// Back end: walks each queued command byte by byte into the output register.
// Depends on blpl_pkg.
module blpl_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_empty_i,
  input  blpl_pkg::cmd_t      q_head_i,
  output logic                q_pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output blpl_pkg::out_item_t out_item_o
);

  logic [blpl_pkg::SEQ_IDX_W-1:0] idx_q, idx_d;
  logic [blpl_pkg::SEQ_IDX_W-1:0] last_idx;
  logic                           out_valid_q, out_valid_d;
  blpl_pkg::out_item_t            out_q, out_d;
  logic                           load;
  logic                           is_last;

  assign load    = !q_empty_i && (!out_valid_q || !out_stall_i);
  assign is_last = idx_q == last_idx;
  assign q_pop_o = load && is_last;

  always_comb begin
    case (q_head_i.kind)
      blpl_pkg::KIND_INIT:   last_idx = blpl_pkg::SEQ_IDX_W'(1);
      blpl_pkg::KIND_FRAME:  last_idx = blpl_pkg::SEQ_IDX_W'(5);
      blpl_pkg::KIND_RESEND: last_idx = blpl_pkg::SEQ_IDX_W'(6);
      default:               last_idx = '0;
    endcase
  end

  always_comb begin
    out_d.tx_valid = q_head_i.kind != blpl_pkg::KIND_NONE;
    out_d.buttons  = q_head_i.buttons;
    out_d.status   = q_head_i.status;
    out_d.last     = is_last;
    case (q_head_i.kind)
      blpl_pkg::KIND_INIT:
        out_d.tx_byte = (idx_q == '0) ? blpl_pkg::CMD_BUTTON_IRQ_ON
                                      : blpl_pkg::CMD_LED_USER;
      blpl_pkg::KIND_FRAME:
        out_d.tx_byte = blpl_pkg::frame_byte(q_head_i.word, idx_q);
      blpl_pkg::KIND_RESEND:
        // IRQ enable first, then the frame shifted by one
        out_d.tx_byte = (idx_q == '0) ? blpl_pkg::CMD_BUTTON_IRQ_ON
                      : blpl_pkg::frame_byte(q_head_i.word,
                                             idx_q - blpl_pkg::SEQ_IDX_W'(1));
      default: out_d.tx_byte = 8'h00;
    endcase
  end

  always_comb begin
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    if (load) begin
      idx_d       = is_last ? '0 : idx_q + 1'b1;
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

`ifndef SYNTH
  a_idx_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !q_empty_i |-> idx_q <= last_idx)
    else $error("byte index beyond command length");

  a_idle_idx_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_empty_i |-> idx_q == '0)
    else $error("byte index not cleared between commands");
`endif

endmodule

// File: rtl/button_led_pad_link_controller.sv
// Host-side controller for a serial button/LED pad: top level.
// Depends on blpl_pkg, blpl_front, blpl_queue and blpl_back.
//
// Input channel (in_valid_i / in_stall_o / in_item_i): one event per
// transaction - a received pad packet, init, read buttons or set LEDs.
// Output channel (out_valid_o / out_stall_i / out_item_o): one transaction
// per command byte to send to the pad, or a single transaction with
// tx_valid low when the event sends nothing. Every item carries the
// remapped button byte and the status; last marks the final item of an event.
// An accepted event is first written into the queue; its first item is then
// loaded from the queue head into the output register. Items then follow
// one per cycle unless out_stall_i holds the output: 1 for a silent event,
// 2 for init, 6 for an LED frame, 7 for the resend after a pad reset; the
// byte sequencer in the back end sets these item counts.
// The front end updates state and queues a command in the accept cycle; a
// two-entry queue lets it take new events back to back while the back end
// is still emitting. When out_stall_i holds the output, the output register
// keeps its item, the back end waits and in_stall_o rises once the queue
// fills.
// Reset: busy clear, both button bytes 0xff, saved LED word zero, queue
// and output empty.
module button_led_pad_link_controller (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  blpl_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output blpl_pkg::out_item_t out_item_o
);

  logic           q_push, q_pop, q_full, q_empty;
  blpl_pkg::cmd_t q_push_cmd, q_head;

  blpl_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_cmd_o    (q_push_cmd)
  );

  blpl_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_cmd_i (q_push_cmd),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .empty_o    (q_empty),
    .head_o     (q_head)
  );

  blpl_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_head_i    (q_head),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule
